@@ design/rahe_pkg.sv @@
`default_nettype none
package rahe_pkg;
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CNT   = 7'b0000010,
        ST_CWAIT = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_FIND  = 7'b0010000,
        ST_FWAIT = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage
`default_nettype wire

@@ design/rahe_ram.sv @@
`default_nettype none
module rahe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ design/rahe_mod.sv @@
`default_nettype none
// Restoring remainder of a 32-bit dividend by a 17-bit divisor, one bit per cycle.
module rahe_mod (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_start,
    input  wire  [31:0]  i_dividend,
    input  wire  [16:0]  i_divisor,
    output logic [16:0]  o_rem,
    output logic         o_busy,
    output logic         o_done
);
    logic [31:0] r_quo;
    logic [16:0] r_rem;
    logic [16:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] w_trial;

    assign w_trial = {r_rem, r_quo[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[30:0], 1'b0};
                if (w_trial >= {1'b0, r_div}) begin
                    r_rem <= 17'(w_trial - {1'b0, r_div});
                end else begin
                    r_rem <= w_trial[16:0];
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rem  = r_rem;
    assign o_busy = r_busy;
    assign o_done = r_done;
endmodule
`default_nettype wire

@@ design/rom_address_homophonic_encoder_unit.sv @@
`default_nettype none
// Load and clear items are completed in the cycle they are accepted. An encode item scans
// the chosen table through its registered memory read port, one byte per cycle, to count
// the matches; if there are any, it runs a 32-step remainder unit and then scans the
// table again up to the chosen occurrence.
// One item is worked on at a time; busy is high until it is finished.
// Synchronous active-low reset clears fills, round-robin position and control, and
// sets table_count to 1. Stored bytes are not cleared. Results cannot be stalled.
module rom_address_homophonic_encoder_unit #(
    parameter int WINDOW_DEPTH = 65536,
    parameter int NUM_TABLES   = 3
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_kind,
    input  wire  [1:0]  i_table_select,
    input  wire  [7:0]  i_data_byte,
    input  wire  [31:0] i_random_draw,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [15:0] o_rom_address,
    output logic [1:0]  o_table_used
);
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = AW + 1;
    localparam int TW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int MW = $clog2(NUM_TABLES * WINDOW_DEPTH);

    rahe_pkg::t_state r_state;
    logic [1:0]    r_tcount;
    logic [1:0]    r_rr;
    logic [FW-1:0] r_fill [NUM_TABLES];
    logic [1:0]    r_t;
    logic [7:0]    r_byte;
    logic [31:0]   r_draw;
    logic [FW-1:0] r_lim;
    logic [FW-1:0] r_idx;      // read address issued
    logic [FW-1:0] r_pidx;     // address of the data now on the read port
    logic          r_pv;
    logic [16:0]   r_count;
    logic [16:0]   r_pick;
    logic          r_strobe;
    logic [15:0]   r_addr;

    logic [1:0]    w_n;
    logic [1:0]    w_t;
    logic          w_accept;
    logic          w_we;
    logic [MW-1:0] w_waddr;
    logic [MW-1:0] w_raddr;
    logic [7:0]    w_rdata;
    logic          w_hit;
    logic [16:0]   w_rem;
    rahe_pkg::t_div_ctl w_div;

    assign w_accept    = start && !busy;
    assign busy        = (r_state != rahe_pkg::ST_IDLE);
    assign o_cfg_ready = !busy;

    always_comb begin
        w_n = r_tcount;
        if (w_n == 2'd0) begin
            w_n = 2'd1;
        end
        if (32'(w_n) > NUM_TABLES) begin
            w_n = 2'(NUM_TABLES);
        end
        w_t = (r_rr >= w_n) ? 2'd0 : r_rr;
    end

    // Writes happen on load items, which are accepted only while the scan is idle.
    assign w_we = w_accept && i_kind == rahe_pkg::KIND_LOAD
                  && 32'(i_table_select) < NUM_TABLES
                  && 32'(r_fill[TW'(i_table_select)]) < WINDOW_DEPTH;
    assign w_waddr = MW'(32'(i_table_select) * WINDOW_DEPTH
                         + 32'(r_fill[TW'(i_table_select)][AW-1:0]));
    assign w_raddr = MW'(32'(r_t) * WINDOW_DEPTH + 32'(r_idx[AW-1:0]));

    rahe_ram #(.WIDTH(8), .DEPTH(NUM_TABLES * WINDOW_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(i_data_byte),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_div.start = (r_state == rahe_pkg::ST_CWAIT) && !r_pv && r_count != 17'd0;
    rahe_mod u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div.start),
        .i_dividend(r_draw),
        .i_divisor (r_count),
        .o_rem     (w_rem),
        .o_busy    (w_div.busy),
        .o_done    (w_div.done)
    );

    assign w_hit = r_pv && (w_rdata == r_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rahe_pkg::ST_IDLE;
            r_tcount <= 2'd1;
            r_rr     <= 2'd0;
            r_pv     <= 1'b0;
            r_strobe <= 1'b0;
            for (int k = 0; k < NUM_TABLES; k++) begin
                r_fill[k] <= '0;
            end
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tcount <= i_cfg_data;
            end
            case (r_state)
                rahe_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        case (i_kind)
                            rahe_pkg::KIND_LOAD: begin
                                if (w_we) begin
                                    r_fill[TW'(i_table_select)] <=
                                        r_fill[TW'(i_table_select)] + FW'(1);
                                end
                            end
                            rahe_pkg::KIND_CLEAR: begin
                                for (int k = 0; k < NUM_TABLES; k++) begin
                                    r_fill[k] <= '0;
                                end
                                r_rr <= 2'd0;
                            end
                            rahe_pkg::KIND_ENCODE: begin
                                r_t     <= w_t;
                                r_rr    <= (w_t + 2'd1 >= w_n) ? 2'd0 : w_t + 2'd1;
                                r_byte  <= i_data_byte;
                                r_draw  <= i_random_draw;
                                r_lim   <= r_fill[TW'(w_t)];
                                r_idx   <= '0;
                                r_pv    <= 1'b0;
                                r_count <= '0;
                                r_state <= rahe_pkg::ST_CNT;
                            end
                            default: ;
                        endcase
                    end
                end
                rahe_pkg::ST_CNT: begin
                    // Counting pass: issue reads and tally matches as data returns.
                    if (w_hit) begin
                        r_count <= r_count + 17'd1;
                    end
                    r_pidx <= r_idx;
                    if (r_idx < r_lim) begin
                        r_pv  <= 1'b1;
                        r_idx <= r_idx + FW'(1);
                    end else begin
                        r_pv    <= 1'b0;
                        r_state <= rahe_pkg::ST_CWAIT;
                    end
                end
                rahe_pkg::ST_CWAIT: begin
                    if (w_hit) begin
                        r_count <= r_count + 17'd1;
                    end
                    r_pv <= 1'b0;
                    if (!r_pv) begin
                        r_state <= (r_count == 17'd0) ? rahe_pkg::ST_IDLE
                                                      : rahe_pkg::ST_DIV;
                    end
                end
                rahe_pkg::ST_DIV: begin
                    if (w_div.done) begin
                        r_pick  <= w_rem;
                        r_idx   <= '0;
                        r_pv    <= 1'b0;
                        r_state <= rahe_pkg::ST_FIND;
                    end
                end
                rahe_pkg::ST_FIND: begin
                    // Second pass: stop at the chosen occurrence.
                    if (w_hit && r_pick == 17'd0) begin
                        r_addr   <= 16'(r_pidx);
                        r_strobe <= 1'b1;
                        r_pv     <= 1'b0;
                        r_state  <= rahe_pkg::ST_FWAIT;
                    end else begin
                        if (w_hit) begin
                            r_pick <= r_pick - 17'd1;
                        end
                        r_pidx <= r_idx;
                        if (r_idx < r_lim) begin
                            r_pv  <= 1'b1;
                            r_idx <= r_idx + FW'(1);
                        end else begin
                            r_pv    <= 1'b0;
                            r_state <= rahe_pkg::ST_DONE;
                        end
                    end
                end
                rahe_pkg::ST_FWAIT: begin
                    r_state <= rahe_pkg::ST_IDLE;
                end
                rahe_pkg::ST_DONE: begin
                    if (w_hit && r_pick == 17'd0) begin
                        r_addr   <= 16'(r_pidx);
                        r_strobe <= 1'b1;
                    end
                    r_pv    <= 1'b0;
                    r_state <= rahe_pkg::ST_IDLE;
                end
                default: r_state <= rahe_pkg::ST_IDLE;
            endcase
        end
    end

    assign o_strobe      = r_strobe;
    assign o_rom_address = r_addr;
    assign o_table_used  = r_t;

    // A result is only produced after an encode that was in progress.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == rahe_pkg::ST_FIND
                     || $past(r_state) == rahe_pkg::ST_DONE)
        else $error("result without encode");
    // The remainder unit only runs during the division phase.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.busy |-> r_state == rahe_pkg::ST_DIV)
        else $error("divider active outside division");
    // The chosen table always holds data when a result appears.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> r_lim != '0)
        else $error("result from empty table");
endmodule
`default_nettype wire
